// File: hdl/sete_pkg.sv
// sete_pkg: shared constants, types and command/status structs for the sprite
// entry tile expander. Used by sete_ctrl, sete_datapath and the top level.
// No dependencies.
`default_nettype none

package sete_pkg;

   // cell edge in pixels
   localparam int TILE_SIZE = 16;

   // field widths
   localparam int WORD_W  = 16;
   localparam int CODE_W  = 13;
   localparam int COLOR_W = 6;
   localparam int PRIO_W  = 2;
   localparam int DIM_W   = 3;
   localparam int XPOS_W  = 18;
   localparam int YPOS_W  = 17;

   // entry word bit positions
   localparam int ENABLE_BIT = 15;
   localparam int FLIP_BIT   = 6;
   localparam int HEIGHT_LSB = 7;
   localparam int WIDTH_LSB  = 10;
   localparam int PRIO_LSB   = 14;
   localparam int SIGN_BIT   = 15;
   localparam int FOLD_BITS  = 9;

   // horizontal position offset
   localparam int X_OFFSET = 128;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic last;
   } dp_sts_type;

endpackage

`default_nettype wire

// File: hdl/sete_datapath.sv
// sete_datapath: priority register, entry decode, and the registered cell
// walker that drives the result fields. Depends on sete_pkg.
`default_nettype none

module sete_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [sete_pkg::PRIO_W-1:0]         csr_wr_data,
   input  wire logic [sete_pkg::WORD_W-1:0]         attr_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         code_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         x_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         y_word,
   input  wire sete_pkg::dp_cmd_type                cmd,
   output sete_pkg::dp_sts_type                     sts,
   output logic [sete_pkg::CODE_W-1:0]              tile_code,
   output logic [sete_pkg::COLOR_W-1:0]             tile_color,
   output logic                                     flip_x,
   output logic signed [sete_pkg::XPOS_W-1:0]       x_pos,
   output logic signed [sete_pkg::YPOS_W-1:0]       y_pos,
   output logic                                     last
);
   import sete_pkg::*;

   localparam logic signed [XPOS_W-1:0] X_STEP = XPOS_W'(TILE_SIZE);
   localparam logic signed [YPOS_W-1:0] Y_STEP = YPOS_W'(TILE_SIZE);

   logic [PRIO_W-1:0]        prio_ff;
   logic [CODE_W-1:0]        code_ff, code_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic                     flip_ff, flip_in;
   logic signed [XPOS_W-1:0] x_ff, x_in;
   logic signed [YPOS_W-1:0] y_ff, y_in;
   logic signed [YPOS_W-1:0] y0_ff, y0_in;
   logic [DIM_W-1:0]         col_ff, col_in;
   logic [DIM_W-1:0]         row_ff, row_in;
   logic [DIM_W-1:0]         wm1_ff, wm1_in;
   logic [DIM_W-1:0]         hm1_ff, hm1_in;

   logic [WORD_W:0]          px;
   logic signed [XPOS_W-1:0] x0;
   logic signed [YPOS_W-1:0] y0;
   logic signed [XPOS_W-1:0] x_span;
   logic [DIM_W-1:0]         dec_wm1;
   logic                     dec_flip;

   // priority select register
   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff <= '0;
      end else if (csr_wr_en) begin
         prio_ff <= csr_wr_data;
      end
   end

   // entry is drawn in this pass
   assign sts.hit = attr_word[ENABLE_BIT] &&
                    (code_word[PRIO_LSB +: PRIO_W] == prio_ff);

   // entry decode and position folding
   always_comb begin
      dec_wm1  = attr_word[WIDTH_LSB +: DIM_W];
      dec_flip = attr_word[FLIP_BIT];
      px       = {1'b0, x_word} + (WORD_W+1)'(X_OFFSET);
      if (px[SIGN_BIT]) begin
         x0 = {{(XPOS_W-FOLD_BITS){1'b1}}, px[FOLD_BITS-1:0]};
      end else begin
         x0 = XPOS_W'(px);
      end
      if (y_word[SIGN_BIT]) begin
         y0 = {{(YPOS_W-FOLD_BITS){1'b1}}, y_word[FOLD_BITS-1:0]};
      end else begin
         y0 = YPOS_W'(y_word);
      end
      // a flipped sprite starts at its rightmost column
      x_span = dec_flip ? XPOS_W'(dec_wm1) * X_STEP : '0;
   end

   // next values of the cell walker
   always_comb begin
      code_in  = code_ff;
      color_in = color_ff;
      flip_in  = flip_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      y0_in    = y0_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      wm1_in   = wm1_ff;
      hm1_in   = hm1_ff;
      if (cmd.load) begin
         code_in  = code_word[CODE_W-1:0];
         color_in = attr_word[COLOR_W-1:0];
         flip_in  = dec_flip;
         x_in     = x0 + x_span;
         y_in     = y0;
         y0_in    = y0;
         col_in   = '0;
         row_in   = '0;
         wm1_in   = dec_wm1;
         hm1_in   = attr_word[HEIGHT_LSB +: DIM_W];
      end else if (cmd.step) begin
         code_in = code_ff + CODE_W'(1);
         if (row_ff != hm1_ff) begin
            // next row in the same column
            row_in = row_ff + DIM_W'(1);
            y_in   = y_ff + Y_STEP;
         end else begin
            // next column, back to the top row
            row_in = '0;
            col_in = col_ff + DIM_W'(1);
            y_in   = y0_ff;
            x_in   = flip_ff ? x_ff - X_STEP : x_ff + X_STEP;
         end
      end
   end

   // cell walker registers, payload only
   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      color_ff <= color_in;
      flip_ff  <= flip_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      y0_ff    <= y0_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      wm1_ff   <= wm1_in;
      hm1_ff   <= hm1_in;
   end

   // result fields
   assign sts.last   = (col_ff == wm1_ff) && (row_ff == hm1_ff);
   assign tile_code  = code_ff;
   assign tile_color = color_ff;
   assign flip_x     = flip_ff;
   assign x_pos      = x_ff;
   assign y_pos      = y_ff;
   assign last       = sts.last;

endmodule

`default_nettype wire

// File: hdl/sete_ctrl.sv
// sete_ctrl: controller state machine for the tile expander handshakes.
// Depends on sete_pkg.
`default_nettype none

module sete_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire sete_pkg::dp_sts_type sts,
   output sete_pkg::dp_cmd_type      cmd
);
   import sete_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_take;
   logic      rsp_take;

   assign req_take  = req_valid && req_ready_ff;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // datapath commands
   assign cmd.load = req_take && sts.hit;
   assign cmd.step = rsp_take && !sts.last;

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && sts.hit) begin
                  state_ff     <= ST_RUN;
                  req_ready_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_RUN: begin
               if (rsp_take && sts.last) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/sprite_entry_tile_expander.sv
// sprite_entry_tile_expander: top level, joins sete_ctrl and sete_datapath.
// Depends on sete_pkg, sete_ctrl and sete_datapath.
//
// usage
//   req channel: one sprite entry per transaction (attr, code, x, y words).
//   rsp channel: one tile command per 16x16 cell, columns outer, rows inner,
//   rsp_last high on the final cell of the sprite.
//   csr port: csr_wr_en with csr_wr_data writes the priority select; write
//   it only while the block is idle.
// latency and throughput
//   an accepted entry shows its first tile command on the next cycle, then
//   one command per cycle while rsp_ready is high; an entry of w x h cells
//   (up to 8x8) occupies the block until its last cell is taken. disabled
//   entries or entries of another priority are dropped with no result and
//   req_ready stays high. the rate is set by the single cell walker in the
//   datapath, which emits one cell per cycle while rsp_ready is high and holds one entry at a time.
// reset
//   synchronous; returns to idle with req_ready high, priority select 0.
// stall
//   when rsp_ready is low the current command holds in its output registers
//   and req_ready stays low until the last cell is taken.
`default_nettype none

module sprite_entry_tile_expander (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [sete_pkg::PRIO_W-1:0]         csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [sete_pkg::WORD_W-1:0]         req_attr_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         req_code_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         req_x_word,
   input  wire logic [sete_pkg::WORD_W-1:0]         req_y_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [sete_pkg::CODE_W-1:0]              rsp_tile_code,
   output logic [sete_pkg::COLOR_W-1:0]             rsp_tile_color,
   output logic                                     rsp_flip_x,
   output logic signed [sete_pkg::XPOS_W-1:0]       rsp_x_pos,
   output logic signed [sete_pkg::YPOS_W-1:0]       rsp_y_pos,
   output logic                                     rsp_last
);
   import sete_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // handshake controller
   sete_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // decode and cell walker
   sete_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .attr_word   (req_attr_word),
      .code_word   (req_code_word),
      .x_word      (req_x_word),
      .y_word      (req_y_word),
      .cmd         (cmd),
      .sts         (sts),
      .tile_code   (rsp_tile_code),
      .tile_color  (rsp_tile_color),
      .flip_x      (rsp_flip_x),
      .x_pos       (rsp_x_pos),
      .y_pos       (rsp_y_pos),
      .last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: hdl/sete_checker.sv
// sete_checker: port-level assertions for sprite_entry_tile_expander, with the
// bind that attaches it. Depends on sete_pkg and the top level.
`default_nettype none

module sete_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sete_pkg::CODE_W-1:0]   rsp_tile_code,
   input wire logic [sete_pkg::COLOR_W-1:0]  rsp_tile_color,
   input wire logic                          rsp_flip_x,
   input wire logic                          rsp_last
);
   import sete_pkg::*;

   // one entry at a time: no new transaction while commands are pending
   a_one_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while commands pending");

   // a stalled command holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_code) && $stable(rsp_last))
      else $error("stalled command changed");

   // codes advance by one within a sprite, attributes stay
   a_code_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid &&
         (rsp_tile_code == CODE_W'($past(rsp_tile_code) + CODE_W'(1))) &&
         $stable(rsp_tile_color) && $stable(rsp_flip_x))
      else $error("tile code or attributes wrong within sprite");

   // after the last cell the block returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("not idle after last cell");

endmodule

bind sprite_entry_tile_expander sete_checker u_sete_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_tile_code  (rsp_tile_code),
   .rsp_tile_color (rsp_tile_color),
   .rsp_flip_x     (rsp_flip_x),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// File: dv/sprite_entry_tile_expander_test.sv
// sprite_entry_tile_expander_test: self-checking bench for the sprite entry tile expander.
// Expands each accepted entry into its expected tile commands and checks the rsp stream.
// Depends on sete_pkg and sprite_entry_tile_expander.

module sprite_entry_tile_expander_test;
   import sete_pkg::*;

   localparam int DRAIN_CYCLES  = 80;    // one full 8x8 entry plus margin
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int HOLD_AFTER    = 300;   // tile commands seen before the hold-off
   localparam int STALL_LIMIT   = 3000;  // cycles with no transaction on either side
   localparam int PHASE_ENTRIES = 73;
   localparam int IDLE_PCT      = 36;

   typedef struct {
      logic [WORD_W-1:0] attr_word;
      logic [WORD_W-1:0] code_word;
      logic [WORD_W-1:0] x_word;
      logic [WORD_W-1:0] y_word;
   } sprite_entry_type;

   typedef struct {
      logic [CODE_W-1:0]        tile_code;
      logic [COLOR_W-1:0]       tile_color;
      logic                     flip_x;
      logic signed [XPOS_W-1:0] x_pos;
      logic signed [YPOS_W-1:0] y_pos;
      logic                     last;
   } tile_cmd_type;

   // block ports, inputs to the block known from time zero
   logic                     clock;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [PRIO_W-1:0]        csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [WORD_W-1:0]        req_attr_word = '0;
   logic [WORD_W-1:0]        req_code_word = '0;
   logic [WORD_W-1:0]        req_x_word = '0;
   logic [WORD_W-1:0]        req_y_word = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CODE_W-1:0]        rsp_tile_code;
   logic [COLOR_W-1:0]       rsp_tile_color;
   logic                     rsp_flip_x;
   logic signed [XPOS_W-1:0] rsp_x_pos;
   logic signed [YPOS_W-1:0] rsp_y_pos;
   logic                     rsp_last;

   // bench state
   sprite_entry_type  pending_entries[$];
   tile_cmd_type      expected_tiles[$];
   sprite_entry_type  offered;
   logic [PRIO_W-1:0] active_priority = '0;
   logic              calm = 1'b0;
   int                error_count = 0;
   int                entries_taken = 0;
   int                entries_expanded = 0;
   int                tiles_checked = 0;
   int                hold_left = 0;
   logic              hold_done = 1'b0;
   int                quiet_cycles = 0;

   sprite_entry_tile_expander uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_attr_word  (req_attr_word),
      .req_code_word  (req_code_word),
      .req_x_word     (req_x_word),
      .req_y_word     (req_y_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_code  (rsp_tile_code),
      .rsp_tile_color (rsp_tile_color),
      .rsp_flip_x     (rsp_flip_x),
      .rsp_x_pos      (rsp_x_pos),
      .rsp_y_pos      (rsp_y_pos),
      .rsp_last       (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // negative positions fold into -512..-1, others pass unchanged
   function automatic int fold_position(input logic [16:0] p);
      if (p[SIGN_BIT]) begin
         return int'({1'b0, p[FOLD_BITS-1:0]}) - 512;
      end
      return int'(p);
   endfunction

   // expand one entry into its tile commands, columns outer, rows inner
   function automatic void expand_entry(input sprite_entry_type e);
      int                x0;
      int                y0;
      int                w;
      int                h;
      int                cx;
      logic [CODE_W-1:0] code;
      tile_cmd_type      t;
      if (!e.attr_word[ENABLE_BIT]) return;
      if (e.code_word[PRIO_LSB +: PRIO_W] != active_priority) return;
      entries_expanded++;
      x0 = fold_position({1'b0, e.x_word} + 17'(X_OFFSET));
      y0 = fold_position({1'b0, e.y_word});
      w = int'(e.attr_word[WIDTH_LSB +: DIM_W]) + 1;
      h = int'(e.attr_word[HEIGHT_LSB +: DIM_W]) + 1;
      code = e.code_word[CODE_W-1:0];
      for (int col = 0; col < w; col++) begin
         cx = e.attr_word[FLIP_BIT] ? (w - 1 - col) : col;
         for (int row = 0; row < h; row++) begin
            t.tile_code  = code;
            t.tile_color = e.attr_word[COLOR_W-1:0];
            t.flip_x     = e.attr_word[FLIP_BIT];
            t.x_pos      = XPOS_W'(x0 + cx * TILE_SIZE);
            t.y_pos      = YPOS_W'(y0 + row * TILE_SIZE);
            t.last       = (col == w - 1) && (row == h - 1);
            expected_tiles.push_back(t);
            code = code + 1'b1;
         end
      end
   endfunction

   // random entry: mostly drawable in the active class, the rest disabled or off-class
   function automatic sprite_entry_type random_entry();
      sprite_entry_type e;
      int               pick;
      e.attr_word = WORD_W'($urandom);
      e.code_word = WORD_W'($urandom);
      e.x_word    = WORD_W'($urandom);
      e.y_word    = WORD_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 80) begin
         e.attr_word[ENABLE_BIT] = 1'b1;
         e.code_word[PRIO_LSB +: PRIO_W] = active_priority;
         // keep most sprites small, a few up to 8x8
         if ($urandom_range(9) != 0) begin
            e.attr_word[WIDTH_LSB +: DIM_W]  = DIM_W'($urandom_range(2));
            e.attr_word[HEIGHT_LSB +: DIM_W] = DIM_W'($urandom_range(2));
         end
      end else if (pick < 90) begin
         e.attr_word[ENABLE_BIT] = 1'b0;
      end else begin
         e.attr_word[ENABLE_BIT] = 1'b1;
         e.code_word[PRIO_LSB +: PRIO_W] = active_priority + PRIO_W'($urandom_range(3, 1));
      end
      // steer positions toward the sign fold
      if ($urandom_range(3) == 0) e.x_word[14:7] = 8'hff;
      if ($urandom_range(3) == 0) e.y_word[14:9] = 6'h3f;
      return e;
   endfunction

   // wait until every entry is taken and every tile command has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_entries.size() != 0 || req_valid || expected_tiles.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_priority(input logic [PRIO_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_priority = value;
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_entries.push_back(random_entry());
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed entries under the reset priority class
      pending_entries.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000}); // disabled
      pending_entries.push_back('{16'h7fff, 16'h0123, 16'h1234, 16'h0456}); // disabled, rest set
      pending_entries.push_back('{16'h8000, 16'h0000, 16'h0000, 16'h0000}); // single cell
      pending_entries.push_back('{16'hffff, 16'h1fff, 16'hffff, 16'h7fff}); // 8x8 flip, code wrap
      pending_entries.push_back('{16'h84c0, 16'h1ffe, 16'h7f80, 16'h8000}); // fold to -512
      pending_entries.push_back('{16'h803f, 16'h0010, 16'h7f7f, 16'hffff}); // largest positive x
      pending_entries.push_back('{16'h8015, 16'h0020, 16'hff80, 16'h8001}); // x past 16 bits
      pending_entries.push_back('{16'h8000, 16'h0030, 16'hff7f, 16'h81ff}); // both fold to -1
      pending_entries.push_back('{16'h8000, 16'h0040, 16'h7fff, 16'h7ff0});
      pending_entries.push_back('{16'h8000, 16'h4000, 16'h0000, 16'h0000}); // other classes
      pending_entries.push_back('{16'h8000, 16'h8000, 16'h0000, 16'h0000});
      pending_entries.push_back('{16'h8000, 16'hc000, 16'h0000, 16'h0000});
      pending_entries.push_back('{16'he380, 16'h0100, 16'h0010, 16'h0020}); // 1 wide, 8 tall
      pending_entries.push_back('{16'h9c00, 16'h0200, 16'h0000, 16'h0100}); // 8 wide, 1 tall
      pending_entries.push_back('{16'h9c40, 16'h0300, 16'h0000, 16'h0100}); // same, flipped
      pending_entries.push_back('{16'h88c2, 16'h0400, 16'h0123, 16'h0045}); // 3x2 flipped
      queue_random(PHASE_ENTRIES);
      wait_idle();

      // walk the other priority classes, one with no idling at all
      write_priority(2'd3);
      queue_random(PHASE_ENTRIES);
      wait_idle();
      write_priority(2'd1);
      calm = 1'b1;
      queue_random(PHASE_ENTRIES);
      wait_idle();
      calm = 1'b0;
      write_priority(2'd2);
      queue_random(PHASE_ENTRIES);
      wait_idle();
      write_priority(2'd0);
      queue_random(PHASE_ENTRIES);
      wait_idle();

      $display("covered %0d entries (%0d expanded) over all priority classes,",
               entries_taken, entries_expanded);
      $display("%0d tile commands checked, with flips, folds, code wrap and a long rsp stall",
               tiles_checked);
      if (error_count == 0) begin
         $display("sprite_entry_tile_expander_test: done, clean");
      end else begin
         $display("sprite_entry_tile_expander_test: done, errors");
      end
      $finish;
   end

   // req driver: predict on accept, then offer the next entry or idle
   always @(posedge clock) begin : req_driver
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expand_entry(offered);
            entries_taken++;
         end
         if (req_valid && !req_ready) begin
            offer = 1'b1;
         end else if (pending_entries.size() != 0 &&
                      (calm || $urandom_range(99) >= IDLE_PCT)) begin
            offered = pending_entries.pop_front();
            req_attr_word <= offered.attr_word;
            req_code_word <= offered.code_word;
            req_x_word    <= offered.x_word;
            req_y_word    <= offered.y_word;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // rsp sink: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && tiles_checked >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // rsp monitor: compare each tile command with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      tile_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tiles.size() == 0) begin
            $error("tile command with nothing expected: code %0d x %0d y %0d",
                   rsp_tile_code, rsp_x_pos, rsp_y_pos);
            error_count++;
         end else begin
            want = expected_tiles.pop_front();
            check_field("tile_code", want.tile_code, rsp_tile_code);
            check_field("tile_color", want.tile_color, rsp_tile_color);
            check_field("flip_x", want.flip_x, rsp_flip_x);
            check_field("x_pos", want.x_pos, rsp_x_pos);
            check_field("y_pos", want.y_pos, rsp_y_pos);
            check_field("last", want.last, rsp_last);
         end
         tiles_checked++;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("sprite_entry_tile_expander_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
